FILE: rtl/core/tgmm_pkg.sv
// Shared types, constants and codes of the timed gain matrix mixer.
// Used by every module of the block; depends on nothing.
package tgmm_pkg;

  localparam int MAX_OBJECTS  = 16;
  localparam int MAX_SPEAKERS = 16;
  localparam int OBJ_W        = $clog2(MAX_OBJECTS);
  localparam int SPK_W        = $clog2(MAX_SPEAKERS);
  localparam int ADDR_W       = OBJ_W + SPK_W;
  localparam int MEM_DEPTH    = MAX_OBJECTS * MAX_SPEAKERS;
  localparam int CNT_W        = 5;
  localparam int GAIN_W       = 16;
  localparam int RATIO_W      = 16;
  localparam int ACC_W        = 36;
  localparam int TIME_W       = 32;
  localparam int LEN_W        = 24;
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  localparam logic [TIME_W-1:0] TIME_NONE = '1;
  localparam logic [LEN_W-1:0]  LEN_NONE  = '1;

  // Item modes.
  localparam logic [1:0] MODE_STAGE  = 2'd0;
  localparam logic [1:0] MODE_COMMIT = 2'd1;
  localparam logic [1:0] MODE_AUDIO  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic REG_NUM_OBJECTS  = 1'b0;
  localparam logic REG_NUM_SPEAKERS = 1'b1;

  // Operation applied to one gain row.
  typedef enum logic [2:0] {
    OP_JUMP,
    OP_RAMP,
    OP_PEND,
    OP_REACH,
    OP_MIX
  } row_op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         object_index;
    logic [3:0]         speaker_index;
    logic signed [15:0] gain_value;
    logic [31:0]        start_time;
    logic [23:0]        transition_duration;
    logic signed [15:0] sample_value;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         out_speaker;
    logic signed [15:0] speaker_sample;
    logic               last_of_frame;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_item;
    logic              stage_write;
    logic              ratio_start;
    logic              row_issue;
    logic [SPK_W-1:0]  row_s;
    row_op_t           row_op;
    logic              obj_sel_scan;
    logic [OBJ_W-1:0]  scan_idx;
    logic              obj_update;
    logic              emit_kind;
    logic [1:0]        kind;
    logic              emit_spk;
    logic [SPK_W-1:0]  emit_idx;
    logic              tick;
    logic              clear_we;
    logic [ADDR_W-1:0] clear_addr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0]       mode;
    logic             start_none;
    logic             start_lt;
    logic             start_eq;
    logic             len_zero;
    logic             retarget;
    logic             obj_in_use;
    logic             obj_last;
    logic [CNT_W-1:0] ns_eff;
    logic             ratio_busy;
    logic             scan_hit;
    logic             out_free;
  } status_t;

endpackage

FILE: rtl/core/tgmm_ratio.sv
// Ramp ratio unit: floor(65536 * (t - t0) / (t1 - t0)), capped at 65535, by restoring division.
// One quotient bit per cycle; depends on tgmm_pkg.
module tgmm_ratio (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tgmm_pkg::TIME_W-1:0]   t,
  input  logic [tgmm_pkg::TIME_W-1:0]   t0,
  input  logic [tgmm_pkg::TIME_W-1:0]   t1,
  output logic                          busy,
  output logic [tgmm_pkg::RATIO_W-1:0]  ratio
);
  import tgmm_pkg::*;

  localparam int STEP_W = $clog2(RATIO_W + 1);

  logic [TIME_W-1:0]  den;
  logic [TIME_W:0]    rem;
  logic [STEP_W-1:0]  steps;
  logic [TIME_W-1:0]  den_in;
  logic [TIME_W-1:0]  num_in;
  logic [TIME_W:0]    rem2;

  assign den_in = t1 - t0;
  assign num_in = t - t0;
  assign rem2   = {rem[TIME_W-1:0], 1'b0};
  assign busy   = (steps != '0);

  // Special spans resolve at once; otherwise shift one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      ratio <= '0;
    end else if (start) begin
      if (t1 == TIME_NONE || den_in == '0) begin
        ratio <= '0;
        steps <= '0;
      end else if (num_in >= den_in) begin
        ratio <= '1;
        steps <= '0;
      end else begin
        den   <= den_in;
        rem   <= {1'b0, num_in};
        ratio <= '0;
        steps <= STEP_W'(RATIO_W);
      end
    end else if (busy) begin
      if (rem2 >= {1'b0, den}) begin
        rem   <= rem2 - {1'b0, den};
        ratio <= {ratio[RATIO_W-2:0], 1'b1};
      end else begin
        rem   <= rem2;
        ratio <= {ratio[RATIO_W-2:0], 1'b0};
      end
      steps <= steps - STEP_W'(1);
    end
  end

endmodule

FILE: rtl/core/tgmm_datapath.sv
// Datapath of the mixer: gain memories, ramp timing, row pipeline,
// speaker accumulators and result register. Depends on tgmm_pkg, tgmm_ratio.
module tgmm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tgmm_pkg::cmd_t      cmd,
  output tgmm_pkg::status_t   sts,
  input  tgmm_pkg::item_t     item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data,
  output logic                result_valid,
  input  logic                result_stall,
  output tgmm_pkg::result_t   result
);
  import tgmm_pkg::*;

  item_t              item_q;
  logic [CNT_W-1:0]   num_objects;
  logic [CNT_W-1:0]   num_speakers;
  logic [TIME_W-1:0]  sample_clock;
  logic signed [GAIN_W-1:0] staged [MAX_SPEAKERS];
  logic [TIME_W-1:0]  ramp_start [MAX_OBJECTS];
  logic [TIME_W-1:0]  ramp_end [MAX_OBJECTS];
  logic [TIME_W-1:0]  pend_start [MAX_OBJECTS];
  logic [LEN_W-1:0]   pend_len [MAX_OBJECTS];
  logic [ACC_W-1:0]   acc [MAX_SPEAKERS];

  logic signed [GAIN_W-1:0] mem_prev [MEM_DEPTH];
  logic signed [GAIN_W-1:0] mem_tgt [MEM_DEPTH];
  logic signed [GAIN_W-1:0] mem_pend [MEM_DEPTH];

  logic [CNT_W-1:0]   no_eff;
  logic [CNT_W-1:0]   ns_eff;
  logic [OBJ_W-1:0]   row_obj;
  logic [TIME_W-1:0]  cur_rs;
  logic [TIME_W-1:0]  cur_re;
  logic [TIME_W-1:0]  cur_ps;
  logic [LEN_W-1:0]   cur_pl;
  logic               retarget;
  logic               due;
  logic               due_jump;
  logic [RATIO_W-1:0] ratio_val;
  logic               ratio_busy;
  logic [TIME_W-1:0]  ratio_t;

  // Row pipeline.
  logic               v1, v2, v3, v4;
  logic [SPK_W-1:0]   s1, s2, s3, s4;
  logic signed [GAIN_W-1:0] rd_prev, rd_tgt, rd_pend, rd_stage;
  logic signed [GAIN_W-1:0] p2_prev, p2_tgt, p2_pend, p2_stage;
  logic signed [GAIN_W-1:0] g3, t3_tgt, t3_pend, t3_stage;
  logic signed [33:0] prod2;
  logic signed [33:0] rnd3;
  logic signed [16:0] diff1;
  logic signed [31:0] mprod;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_prev_en, wr_tgt_en, wr_pend_en;
  logic signed [GAIN_W-1:0] wr_prev_val, wr_tgt_val, wr_pend_val;

  logic [SPK_W-1:0]   acc_idx;
  logic [ACC_W-1:0]   acc_rd;
  logic signed [ACC_W:0] acc_rnd;
  logic signed [22:0] acc_sh;
  logic signed [GAIN_W-1:0] sat_val;
  logic               out_free;
  logic [TIME_W:0]    end_sum;
  logic [TIME_W-1:0]  end_time;
  logic [LEN_W-1:0]   end_len;

  // Effective object and speaker counts.
  always_comb begin
    if (num_objects == '0) no_eff = CNT_W'(1);
    else if (num_objects > CNT_W'(MAX_OBJECTS)) no_eff = CNT_W'(MAX_OBJECTS);
    else no_eff = num_objects;
    if (num_speakers == '0) ns_eff = CNT_W'(1);
    else if (num_speakers > CNT_W'(MAX_SPEAKERS)) ns_eff = CNT_W'(MAX_SPEAKERS);
    else ns_eff = num_speakers;
  end

  // Timing of the object that the current operation addresses.
  assign row_obj  = cmd.obj_sel_scan ? cmd.scan_idx : item_q.object_index[OBJ_W-1:0];
  assign cur_rs   = ramp_start[row_obj];
  assign cur_re   = ramp_end[row_obj];
  assign cur_ps   = pend_start[row_obj];
  assign cur_pl   = pend_len[row_obj];
  assign retarget = item_q.start_time < cur_re;
  assign due      = (cur_ps == sample_clock);
  assign due_jump = (cur_pl == '0);

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    sts            = '0;
    sts.mode       = item_q.mode;
    sts.start_none = (item_q.start_time == TIME_NONE);
    sts.start_lt   = (item_q.start_time < sample_clock);
    sts.start_eq   = (item_q.start_time == sample_clock);
    sts.len_zero   = (item_q.transition_duration == '0);
    sts.retarget   = retarget;
    sts.obj_in_use = ({1'b0, item_q.object_index} < no_eff);
    sts.obj_last   = ({1'b0, item_q.object_index} == no_eff - CNT_W'(1));
    sts.ns_eff     = ns_eff;
    sts.ratio_busy = ratio_busy;
    sts.scan_hit   = (cur_re != TIME_NONE) && (cur_re == sample_clock);
    sts.out_free   = out_free;
  end

  // Ratio of the running ramp, at the transition start or at the current time.
  assign ratio_t = (cmd.row_op == OP_PEND) ? item_q.start_time : sample_clock;

  tgmm_ratio u_ratio (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.ratio_start),
    .t     (ratio_t),
    .t0    (cur_rs),
    .t1    (cur_re),
    .busy  (ratio_busy),
    .ratio (ratio_val)
  );

  // Item register and configuration.
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_q <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_objects  <= CNT_W'(16);
      num_speakers <= CNT_W'(16);
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_OBJECTS) num_objects <= cfg_data;
      else num_speakers <= cfg_data;
    end
  end

  // Staged gain row.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SPEAKERS; i++) staged[i] <= '0;
    end else if (cmd.stage_write) begin
      staged[item_q.speaker_index[SPK_W-1:0]] <= item_q.gain_value;
    end
  end

  // Ramp end clipped below the no-end mark.
  assign end_len  = (cmd.row_op == OP_REACH) ? cur_pl : item_q.transition_duration;
  assign end_sum  = {1'b0, sample_clock} + {{(TIME_W + 1 - LEN_W){1'b0}}, end_len};
  assign end_time = (end_sum >= {1'b0, TIME_NONE}) ? (TIME_NONE - TIME_W'(1))
                                                   : end_sum[TIME_W-1:0];

  // Sample clock and per-object timing.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_clock <= '0;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        ramp_start[i] <= '0;
        ramp_end[i]   <= TIME_NONE;
        pend_start[i] <= TIME_NONE;
        pend_len[i]   <= LEN_NONE;
      end
    end else begin
      if (cmd.tick) sample_clock <= sample_clock + TIME_W'(1);
      if (cmd.obj_update) begin
        case (cmd.row_op)
          OP_JUMP: begin
            ramp_end[row_obj]   <= TIME_NONE;
            ramp_start[row_obj] <= sample_clock;
            pend_start[row_obj] <= TIME_NONE;
            pend_len[row_obj]   <= LEN_NONE;
          end
          OP_RAMP: begin
            ramp_end[row_obj]   <= end_time;
            ramp_start[row_obj] <= sample_clock;
            pend_start[row_obj] <= TIME_NONE;
            pend_len[row_obj]   <= LEN_NONE;
          end
          OP_PEND: begin
            if (retarget) ramp_end[row_obj] <= item_q.start_time;
            pend_start[row_obj] <= item_q.start_time;
            pend_len[row_obj]   <= item_q.transition_duration;
          end
          OP_REACH: begin
            ramp_start[row_obj] <= sample_clock;
            if (due) begin
              ramp_end[row_obj]   <= due_jump ? TIME_NONE : end_time;
              pend_start[row_obj] <= TIME_NONE;
              pend_len[row_obj]   <= LEN_NONE;
            end else begin
              ramp_end[row_obj] <= cur_ps;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Row pipeline: read, ramp product, gain, write or mix product.
  assign rd_addr = {row_obj, cmd.row_s};
  assign diff1   = {rd_tgt[GAIN_W-1], rd_tgt} - {rd_prev[GAIN_W-1], rd_prev};
  assign rnd3    = prod2 + 34'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.row_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && (cmd.row_op == OP_MIX);
    end
  end

  always_ff @(posedge clk) begin
    rd_prev  <= mem_prev[rd_addr];
    rd_tgt   <= mem_tgt[rd_addr];
    rd_pend  <= mem_pend[rd_addr];
    rd_stage <= staged[cmd.row_s];
    s1       <= cmd.row_s;
    prod2    <= $signed({1'b0, ratio_val}) * diff1;
    p2_prev  <= rd_prev;
    p2_tgt   <= rd_tgt;
    p2_pend  <= rd_pend;
    p2_stage <= rd_stage;
    s2       <= s1;
    g3       <= p2_prev + rnd3[31:16];
    t3_tgt   <= p2_tgt;
    t3_pend  <= p2_pend;
    t3_stage <= p2_stage;
    s3       <= s2;
    mprod    <= g3 * item_q.sample_value;
    s4       <= s3;
  end

  // Row write selection.
  always_comb begin
    wr_prev_en  = 1'b0;
    wr_tgt_en   = 1'b0;
    wr_pend_en  = 1'b0;
    wr_prev_val = t3_stage;
    wr_tgt_val  = t3_stage;
    wr_pend_val = t3_stage;
    wr_addr     = {row_obj, s3};
    if (cmd.clear_we) begin
      wr_prev_en  = 1'b1;
      wr_tgt_en   = 1'b1;
      wr_pend_en  = 1'b1;
      wr_prev_val = '0;
      wr_tgt_val  = '0;
      wr_pend_val = '0;
      wr_addr     = cmd.clear_addr;
    end else if (v3) begin
      case (cmd.row_op)
        OP_JUMP: begin
          wr_prev_en = 1'b1;
          wr_tgt_en  = 1'b1;
          wr_pend_en = 1'b1;
        end
        OP_RAMP: begin
          wr_prev_en  = 1'b1;
          wr_prev_val = g3;
          wr_tgt_en   = 1'b1;
          wr_pend_en  = 1'b1;
        end
        OP_PEND: begin
          wr_pend_en = 1'b1;
          wr_tgt_en  = retarget;
          wr_tgt_val = g3;
        end
        OP_REACH: begin
          wr_prev_en = 1'b1;
          if (due) begin
            wr_prev_val = due_jump ? t3_pend : t3_tgt;
            wr_tgt_en   = 1'b1;
            wr_tgt_val  = t3_pend;
          end else begin
            wr_prev_val = t3_tgt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_prev_en) mem_prev[wr_addr] <= wr_prev_val;
    if (wr_tgt_en) mem_tgt[wr_addr] <= wr_tgt_val;
    if (wr_pend_en) mem_pend[wr_addr] <= wr_pend_val;
  end

  // Speaker accumulators: mixed in from the pipeline, read out at frame end.
  assign acc_idx = cmd.emit_spk ? cmd.emit_idx : s4;
  assign acc_rd  = acc[acc_idx];
  assign acc_rnd = $signed({acc_rd[ACC_W-1], acc_rd}) + (ACC_W + 1)'(8192);
  assign acc_sh  = acc_rnd[ACC_W:14];

  always_comb begin
    if (acc_sh > 23'sd32767) sat_val = 16'sh7FFF;
    else if (acc_sh < -23'sd32768) sat_val = -16'sh8000;
    else sat_val = acc_sh[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SPEAKERS; i++) acc[i] <= '0;
    end else if (cmd.emit_spk) begin
      acc[acc_idx] <= '0;
    end else if (v4) begin
      acc[acc_idx] <= acc_rd + {{(ACC_W - 32){mprod[31]}}, mprod};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_kind || cmd.emit_spk) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_kind) begin
      result.kind           <= cmd.kind;
      result.out_speaker    <= '0;
      result.speaker_sample <= '0;
      result.last_of_frame  <= 1'b0;
    end else if (cmd.emit_spk) begin
      result.kind           <= KIND_SAMPLE;
      result.out_speaker    <= 4'(cmd.emit_idx);
      result.speaker_sample <= sat_val;
      result.last_of_frame  <= ({1'b0, cmd.emit_idx} == ns_eff - CNT_W'(1));
    end
  end

endmodule

FILE: rtl/core/tgmm_ctrl.sv
// Controller of the mixer: sequences memory clear, item decode, ratio, row passes,
// timing updates, result beats and the ramp end scan. Depends on tgmm_pkg.
module tgmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  tgmm_pkg::status_t   sts,
  output tgmm_pkg::cmd_t      cmd
);
  import tgmm_pkg::*;

  typedef enum logic [11:0] {
    ST_CLEAR      = 12'b0000_0000_0001,
    ST_IDLE       = 12'b0000_0000_0010,
    ST_DECODE     = 12'b0000_0000_0100,
    ST_RATIO_GO   = 12'b0000_0000_1000,
    ST_RATIO_WAIT = 12'b0000_0001_0000,
    ST_ROW_ISSUE  = 12'b0000_0010_0000,
    ST_ROW_DRAIN  = 12'b0000_0100_0000,
    ST_OBJ_UPD    = 12'b0000_1000_0000,
    ST_EMIT_KIND  = 12'b0001_0000_0000,
    ST_EMIT_SPK   = 12'b0010_0000_0000,
    ST_TICK       = 12'b0100_0000_0000,
    ST_SCAN       = 12'b1000_0000_0000
  } state_t;

  state_t            state, state_next;
  row_op_t           op, op_next;
  logic [1:0]        kind, kind_next;
  logic              use_scan, use_scan_next;
  logic [SPK_W-1:0]  cnt, cnt_next;
  logic [OBJ_W-1:0]  scan_k, scan_k_next;
  logic [DRAIN_W-1:0] drain, drain_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic              row_last;
  logic              spk_last;
  logic              scan_last;

  assign item_stall = (state != ST_IDLE);
  assign spk_last   = ({1'b0, cnt} == sts.ns_eff - CNT_W'(1));
  assign row_last   = (op == OP_MIX) ? spk_last : (cnt == SPK_W'(MAX_SPEAKERS - 1));
  assign scan_last  = (scan_k == OBJ_W'(MAX_OBJECTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      op       <= OP_JUMP;
      kind     <= KIND_ACCEPT;
      use_scan <= 1'b0;
      cnt      <= '0;
      scan_k   <= '0;
      drain    <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      kind     <= kind_next;
      use_scan <= use_scan_next;
      cnt      <= cnt_next;
      scan_k   <= scan_k_next;
      drain    <= drain_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    kind_next     = kind;
    use_scan_next = use_scan;
    cnt_next      = cnt;
    scan_k_next   = scan_k;
    drain_next    = drain;
    clr_addr_next = clr_addr;

    cmd              = '0;
    cmd.row_op       = op;
    cmd.obj_sel_scan = use_scan;
    cmd.scan_idx     = scan_k;
    cmd.row_s        = cnt;
    cmd.emit_idx     = cnt;
    cmd.kind         = kind;
    cmd.clear_addr   = clr_addr;

    case (state)
      // Zero the gain memories after reset.
      ST_CLEAR: begin
        cmd.clear_we  = 1'b1;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          use_scan_next = 1'b0;
          state_next    = ST_DECODE;
        end
      end

      // Choose the work for the item just taken.
      ST_DECODE: begin
        cnt_next   = '0;
        state_next = ST_IDLE;
        case (sts.mode)
          MODE_STAGE: begin
            cmd.stage_write = 1'b1;
          end
          MODE_COMMIT: begin
            if (sts.start_none) begin
              state_next = ST_IDLE;
            end else if (sts.start_lt) begin
              kind_next  = KIND_REJECT;
              state_next = ST_EMIT_KIND;
            end else if (sts.start_eq) begin
              if (sts.len_zero) begin
                op_next    = OP_JUMP;
                state_next = ST_ROW_ISSUE;
              end else begin
                op_next    = OP_RAMP;
                state_next = ST_RATIO_GO;
              end
            end else begin
              op_next    = OP_PEND;
              state_next = sts.retarget ? ST_RATIO_GO : ST_ROW_ISSUE;
            end
          end
          MODE_AUDIO: begin
            if (sts.obj_in_use) begin
              op_next    = OP_MIX;
              state_next = ST_RATIO_GO;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_RATIO_GO: begin
        cmd.ratio_start = 1'b1;
        state_next      = ST_RATIO_WAIT;
      end

      ST_RATIO_WAIT: begin
        if (!sts.ratio_busy) begin
          cnt_next   = '0;
          state_next = ST_ROW_ISSUE;
        end
      end

      // One gain entry enters the row pipeline per cycle.
      ST_ROW_ISSUE: begin
        cmd.row_issue = 1'b1;
        if (row_last) begin
          drain_next = '0;
          state_next = ST_ROW_DRAIN;
        end else begin
          cnt_next = cnt + SPK_W'(1);
        end
      end

      ST_ROW_DRAIN: begin
        if (drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
          cnt_next = '0;
          if (op == OP_MIX) begin
            state_next = sts.obj_last ? ST_EMIT_SPK : ST_IDLE;
          end else begin
            state_next = ST_OBJ_UPD;
          end
        end else begin
          drain_next = drain + DRAIN_W'(1);
        end
      end

      ST_OBJ_UPD: begin
        cmd.obj_update = 1'b1;
        if (op == OP_REACH) begin
          if (scan_last) begin
            state_next = ST_IDLE;
          end else begin
            scan_k_next = scan_k + OBJ_W'(1);
            state_next  = ST_SCAN;
          end
        end else begin
          kind_next  = KIND_ACCEPT;
          state_next = ST_EMIT_KIND;
        end
      end

      ST_EMIT_KIND: begin
        if (sts.out_free) begin
          cmd.emit_kind = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      // One speaker sum per beat at the end of a frame.
      ST_EMIT_SPK: begin
        if (sts.out_free) begin
          cmd.emit_spk = 1'b1;
          if (spk_last) begin
            state_next = ST_TICK;
          end else begin
            cnt_next = cnt + SPK_W'(1);
          end
        end
      end

      ST_TICK: begin
        cmd.tick      = 1'b1;
        scan_k_next   = '0;
        use_scan_next = 1'b1;
        state_next    = ST_SCAN;
      end

      // Look at each object for a ramp ending at the new time.
      ST_SCAN: begin
        if (sts.scan_hit) begin
          op_next    = OP_REACH;
          cnt_next   = '0;
          state_next = ST_ROW_ISSUE;
        end else if (scan_last) begin
          state_next = ST_IDLE;
        end else begin
          scan_k_next = scan_k + OBJ_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/timed_gain_matrix_mixer_core.sv
// Timed gain matrix mixer: top level joining controller and datapath.
// Depends on tgmm_pkg, tgmm_ctrl, tgmm_datapath.
//
// Usage. Items arrive on item/item_valid/item_stall; a beat moves when
// valid is high and stall is low. Mode 0 stages one gain of a row, mode 1
// commits the staged row to an object as a timed transition, mode 2 mixes
// one object sample. Results leave on result/result_valid/result_stall:
// one beat per accepted or rejected commit, and at the close of a frame
// (sample of the last object in use) one beat per speaker in use.
// Configuration writes use cfg_we/cfg_index/cfg_data while the block idles.
// Timing. The block works on one item at a time. An accepted commit
// runs a row pass and a timing update, first evaluating the running
// ramp when it must (ratio division, one quotient bit per cycle). An
// audio sample runs ratio division, then one gain entry per cycle through
// the row pipeline. A frame close adds one beat per speaker in use, a
// scan of the objects, and a row pass for each object whose ramp ends.
// Reset clears control state, timing, the staged row and accumulators;
// then a pass over every address zeroes the gain memories with
// item_stall high. A stalled result holds in the output register; the
// block keeps working until it has another result to present.
module timed_gain_matrix_mixer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  tgmm_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output tgmm_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);
  import tgmm_pkg::*;

  cmd_t    cmd;
  status_t sts;

  tgmm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  tgmm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of timed_gain_matrix_mixer_core: directed and random items,
// a scoreboard class that predicts every result beat, random idling on both channels.
// Depends on tgmm_pkg and the RTL of the block.
`timescale 1ns / 1ps

import tgmm_pkg::*;

// Predicts the mixer's results and checks the beats that leave it.
class mix_scoreboard;
  bit [4:0]  num_obj_reg;
  bit [4:0]  num_spk_reg;
  bit [31:0] sample_time;
  int        prev_g[MEM_DEPTH];
  int        tgt_g[MEM_DEPTH];
  int        pend_g[MEM_DEPTH];
  int        staged[MAX_SPEAKERS];
  bit [31:0] r_start[MAX_OBJECTS];
  bit [31:0] r_end[MAX_OBJECTS];
  bit [31:0] p_start[MAX_OBJECTS];
  bit [23:0] p_len[MAX_OBJECTS];
  bit [35:0] acc[MAX_SPEAKERS];
  result_t   due_beats[$];
  int        errors;

  function new();
    num_obj_reg = 5'd16;
    num_spk_reg = 5'd16;
    sample_time = '0;
    errors = 0;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      prev_g[i] = 0;
      tgt_g[i] = 0;
      pend_g[i] = 0;
    end
    for (int i = 0; i < MAX_SPEAKERS; i++) begin
      staged[i] = 0;
      acc[i] = '0;
    end
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      r_start[i] = '0;
      r_end[i] = TIME_NONE;
      p_start[i] = TIME_NONE;
      p_len[i] = LEN_NONE;
    end
  endfunction

  function int outstanding();
    return due_beats.size();
  endfunction

  // Register values of zero read as one; values above the maximum clamp.
  function int eff_objects();
    if (num_obj_reg == 0) return 1;
    return (num_obj_reg > MAX_OBJECTS) ? MAX_OBJECTS : int'(num_obj_reg);
  endfunction

  function int eff_speakers();
    if (num_spk_reg == 0) return 1;
    return (num_spk_reg > MAX_SPEAKERS) ? MAX_SPEAKERS : int'(num_spk_reg);
  endfunction

  // Ramp position in Q0.16.
  function bit [31:0] ramp_ratio(bit [31:0] t, bit [31:0] t0, bit [31:0] t1);
    bit [31:0] den;
    bit [31:0] num;
    bit [47:0] wide;
    if (t1 == TIME_NONE) return 0;
    den = t1 - t0;
    num = t - t0;
    if (den == 0) return 0;
    if (num >= den) return 65535;
    wide = {num, 16'h0000};
    return 32'(wide / den);
  endfunction

  // Linear blend with rounding to nearest, ties toward plus infinity.
  function int blend(int a, int b, bit [31:0] r);
    longint prod;
    prod = longint'(r) * longint'(b - a);
    return a + int'((prod + 64'sd32768) >>> 16);
  endfunction

  function bit [31:0] ramp_stop(bit [31:0] now, bit [23:0] len);
    bit [32:0] e;
    e = {1'b0, now} + {9'd0, len};
    return (e >= {1'b0, TIME_NONE}) ? TIME_NONE - 1 : e[31:0];
  endfunction

  function void ramp_end_reached(int o);
    int b;
    b = o * MAX_SPEAKERS;
    r_start[o] = sample_time;
    if (p_start[o] == sample_time) begin
      for (int s = 0; s < MAX_SPEAKERS; s++)
        prev_g[b+s] = (p_len[o] == 0) ? pend_g[b+s] : tgt_g[b+s];
      r_end[o] = (p_len[o] == 0) ? TIME_NONE : ramp_stop(sample_time, p_len[o]);
      for (int s = 0; s < MAX_SPEAKERS; s++) tgt_g[b+s] = pend_g[b+s];
      p_start[o] = TIME_NONE;
      p_len[o] = LEN_NONE;
    end else begin
      r_end[o] = p_start[o];
      for (int s = 0; s < MAX_SPEAKERS; s++) prev_g[b+s] = tgt_g[b+s];
    end
  endfunction

  function void push_status(bit [1:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    due_beats.push_back(r);
  endfunction

  function void commit_row(int o, bit [31:0] start, bit [23:0] len);
    int b;
    bit [31:0] r;
    b = o * MAX_SPEAKERS;
    if (start == TIME_NONE) return;
    if (start < sample_time) begin
      push_status(KIND_REJECT);
      return;
    end
    if (start == sample_time) begin
      if (len == 0) begin
        for (int s = 0; s < MAX_SPEAKERS; s++) begin
          prev_g[b+s] = staged[s];
          tgt_g[b+s] = staged[s];
        end
        r_end[o] = TIME_NONE;
      end else begin
        r = ramp_ratio(sample_time, r_start[o], r_end[o]);
        for (int s = 0; s < MAX_SPEAKERS; s++) begin
          prev_g[b+s] = blend(prev_g[b+s], tgt_g[b+s], r);
          tgt_g[b+s] = staged[s];
        end
        r_end[o] = ramp_stop(sample_time, len);
      end
      r_start[o] = sample_time;
      p_start[o] = TIME_NONE;
      p_len[o] = LEN_NONE;
      for (int s = 0; s < MAX_SPEAKERS; s++) pend_g[b+s] = tgt_g[b+s];
    end else begin
      // A later start cuts the running ramp short at the gain it reaches then.
      if (start < r_end[o]) begin
        r = ramp_ratio(start, r_start[o], r_end[o]);
        for (int s = 0; s < MAX_SPEAKERS; s++)
          tgt_g[b+s] = blend(prev_g[b+s], tgt_g[b+s], r);
        r_end[o] = start;
      end
      p_start[o] = start;
      p_len[o] = len;
      for (int s = 0; s < MAX_SPEAKERS; s++) pend_g[b+s] = staged[s];
    end
    push_status(KIND_ACCEPT);
  endfunction

  function void mix_sample(int o, int x);
    int no;
    int ns;
    int g;
    bit [31:0] r;
    bit [35:0] p;
    longint sacc;
    longint v;
    result_t beat;
    no = eff_objects();
    ns = eff_speakers();
    if (o >= no) return;
    r = ramp_ratio(sample_time, r_start[o], r_end[o]);
    for (int s = 0; s < ns; s++) begin
      g = blend(prev_g[o*MAX_SPEAKERS+s], tgt_g[o*MAX_SPEAKERS+s], r);
      p = 36'(longint'(g) * longint'(x));
      acc[s] = acc[s] + p;
    end
    if (o != no - 1) return;
    // Frame close: emit rounded, saturated sums, advance the clock and handle ramp ends.
    for (int s = 0; s < ns; s++) begin
      sacc = longint'($signed(acc[s]));
      v = (sacc + 64'sd8192) >>> 14;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      beat = '0;
      beat.kind = KIND_SAMPLE;
      beat.out_speaker = 4'(s);
      beat.speaker_sample = 16'(v);
      beat.last_of_frame = (s == ns - 1);
      due_beats.push_back(beat);
      acc[s] = '0;
    end
    sample_time = sample_time + 1;
    for (int k = 0; k < MAX_OBJECTS; k++)
      if (r_end[k] != TIME_NONE && r_end[k] == sample_time) ramp_end_reached(k);
  endfunction

  function void note_item(item_t it);
    case (it.mode)
      MODE_STAGE:  staged[it.speaker_index] = int'(it.gain_value);
      MODE_COMMIT: commit_row(it.object_index, it.start_time, it.transition_duration);
      MODE_AUDIO:  mix_sample(it.object_index, int'(it.sample_value));
      default: ;
    endcase
  endfunction

  function void check_beat(result_t got);
    result_t want;
    if (due_beats.size() == 0) begin
      errors++;
      if (errors <= 30)
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
      return;
    end
    want = due_beats.pop_front();
    if (got.kind !== want.kind || got.out_speaker !== want.out_speaker ||
        got.speaker_sample !== want.speaker_sample ||
        got.last_of_frame !== want.last_of_frame) begin
      errors++;
      if (errors <= 30)
        $display("%0t: mismatch expected k=%0d s=%0d v=%0d l=%0d actual k=%0d s=%0d v=%0d l=%0d",
                 $time, want.kind, want.out_speaker, want.speaker_sample,
                 want.last_of_frame, got.kind, got.out_speaker, got.speaker_sample,
                 got.last_of_frame);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 800;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_we = 1'b0;
  logic    cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  mix_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int cycles = 0;
  int obj_cursor = 0;

  timed_gain_matrix_mixer_core DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall, changed at the falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Check accepted result beats and watch the run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid && !result_stall) sb.check_beat(result);
    if (cycles > CYCLE_LIMIT) begin
      $display("** timed_gain_matrix_mixer_core: FAILED **");
      $finish;
    end
  end

  // Present one item beat and hold it until the block takes it; starts and ends at negedge.
  task automatic send_item(item_t it);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    item_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Write both count registers while the block idles.
  task automatic set_counts(bit [4:0] no, bit [4:0] ns);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_OBJECTS;
    cfg_data <= no;
    @(negedge clk);
    cfg_index <= REG_NUM_SPEAKERS;
    cfg_data <= ns;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.num_obj_reg = no;
    sb.num_spk_reg = ns;
  endtask

  function automatic item_t mk(bit [1:0] m, int o, int s, int g, bit [31:0] st,
                               bit [23:0] d, int x);
    item_t it;
    it.mode = m;
    it.object_index = 4'(o);
    it.speaker_index = 4'(s);
    it.gain_value = 16'(g);
    it.start_time = st;
    it.transition_duration = d;
    it.sample_value = 16'(x);
    return it;
  endfunction

  function automatic bit [15:0] pick_16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed traffic: staged rows, timed commits near now, frames in order.
  function automatic item_t make_item();
    item_t it;
    int sel;
    int no;
    bit [31:0] now;
    no = sb.eff_objects();
    now = sb.sample_time;
    it = mk(MODE_STAGE, $urandom, $urandom, $urandom, $urandom, 24'($urandom), $urandom);
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      it.mode = MODE_STAGE;
      it.gain_value = pick_16();
    end else if (sel < 45) begin
      it.mode = MODE_COMMIT;
      it.object_index = 4'($urandom_range(0, no - 1));
      case ($urandom_range(0, 9))
        0: it.start_time = TIME_NONE;
        1: it.start_time = (now == 0) ? now : now - 1;
        2: ;
        3, 4: it.start_time = now;
        default: it.start_time = now + $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: it.transition_duration = '0;
        3: ;
        default: it.transition_duration = 24'($urandom_range(1, 8));
      endcase
    end else if (sel < 95) begin
      it.mode = MODE_AUDIO;
      it.sample_value = pick_16();
      if ($urandom_range(0, 9) == 0) begin
        it.object_index = 4'($urandom);
      end else begin
        it.object_index = 4'(obj_cursor);
        obj_cursor = (obj_cursor + 1) % no;
      end
    end else begin
      it.mode = 2'd3;
    end
    return it;
  endfunction

  initial begin
    bit [4:0] cfg_obj[7];
    bit [4:0] cfg_spk[7];
    int idle_src[4];
    int idle_sink[4];
    cfg_obj = '{5'd1, 5'd16, 5'd0, 5'd3, 5'd2, 5'd31, 5'd4};
    cfg_spk = '{5'd1, 5'd16, 5'd31, 5'd4, 5'd16, 5'd0, 5'd3};
    idle_src = '{0, 83, 0, 9};
    idle_sink = '{0, 0, 83, 9};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: one object, all speakers.
    set_counts(5'd1, 5'd16);
    send_item(mk(MODE_STAGE, 0, 0, 16384, 0, 0, 0));
    send_item(mk(MODE_STAGE, 0, 15, -32768, 0, 0, 0));
    send_item(mk(MODE_STAGE, 0, 1, 32767, 0, 0, 0));
    send_item(mk(MODE_COMMIT, 0, 0, 0, 0, 0, 0));
    send_item(mk(MODE_AUDIO, 0, 0, 0, 0, 0, 32767));
    send_item(mk(MODE_COMMIT, 0, 0, 0, TIME_NONE, 0, 0));
    send_item(mk(MODE_COMMIT, 0, 0, 0, 0, 3, 0));
    send_item(mk(MODE_STAGE, 0, 0, -16384, 0, 0, 0));
    send_item(mk(MODE_COMMIT, 0, 0, 0, 1, 4, 0));
    send_item(mk(MODE_COMMIT, 0, 0, 0, 3, 0, 0));
    send_item(mk(MODE_COMMIT, 0, 0, 0, 6, 2, 0));
    send_item(mk(MODE_AUDIO, 7, 0, 0, 0, 0, 1000));
    send_item(mk(2'd3, 15, 15, -1, TIME_NONE, LEN_NONE, -1));
    for (int i = 0; i < 8; i++)
      send_item(mk(MODE_AUDIO, 0, 0, 0, 0, 0, (i % 2) ? -32768 : 12345));
    send_item(mk(MODE_COMMIT, 0, 0, 0, 32'hFFFF_FFFE, LEN_NONE, 0));
    send_item(mk(MODE_AUDIO, 0, 0, 0, 0, 0, -1));

    // Random phases over several counts and idling patterns.
    for (int p = 0; p < 7; p++) begin
      set_counts(cfg_obj[p], cfg_spk[p]);
      obj_cursor = 0;
      src_idle_pct = idle_src[p % 4];
      sink_stall_pct = idle_sink[p % 4];
      for (int i = 0; i < 35; i++) begin
        if (p == 2 && i == 20) wait_all_results();
        send_item(make_item());
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** timed_gain_matrix_mixer_core: PASSED **");
    end else begin
      $display("** timed_gain_matrix_mixer_core: FAILED **");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/tgmm_pkg.sv
rtl/core/tgmm_ratio.sv
rtl/core/tgmm_datapath.sv
rtl/core/tgmm_ctrl.sv
rtl/core/timed_gain_matrix_mixer_core.sv
tb/tb_top.sv
